[hw/rtl/srw_pkg.sv]
package srw_pkg;

   // Field widths of the two channels.
   localparam int SEQ_W       = 16;
   localparam int MASK_W      = 32;
   localparam int MASK_IDX_W  = 5;
   localparam int RSP_TDATA_W = 56;

   // One window slot: the full sequence number and a valid flag.
   typedef struct packed {
      logic             valid;
      logic [SEQ_W-1:0] seq;
   } slot_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_CHECK,
      ST_MASK,
      ST_DONE
   } state_type;

   // Control strobes that the sequencer hands to the datapath.
   typedef struct packed {
      logic ready;
      logic mod_start;
      logic wr_clear;
      logic wr_item;
      logic rd_item;
      logic load_rsp;
   } ctrl_type;

   // Wrap-aware compare: a is newer than b over half the number range.
   function automatic logic seq_newer(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] d;
      d = a - b;
      return ((d != '0) && !d[SEQ_W-1]) ||
             ((d == {1'b1, {(SEQ_W-1){1'b0}}}) && (a > b));
   endfunction

endpackage

[hw/rtl/srw_slot_ram.sv]
module srw_slot_ram
   import srw_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  slot_type                 wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output slot_type                 rd_data
);

   slot_type mem_ff [DEPTH];
   slot_type rd_data_ff;

   // One write port and one read port with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/srw_mod_unit.sv]
module srw_mod_unit
   import srw_pkg::*;
#(
   parameter int WINDOW_SIZE = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [SEQ_W-1:0]               value,
   output logic                           done,
   output logic [$clog2(WINDOW_SIZE)-1:0] rem
);

   localparam int SLOT_W = $clog2(WINDOW_SIZE);

   logic [SLOT_W-1:0] rem_ff;
   logic              done_ff;

   // Control: a one-cycle done pulse right after each start.
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   // The window size is a power of two, so the slot index is the low bits of the number.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= value[SLOT_W-1:0];
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

[hw/rtl/seq_receive_window_ack_bits.sv]
// Channel | Ports                                   | Carries
// req     | req_tvalid, req_tready, req_tdata[15:0] | one received sequence number
// rsp     | rsp_tvalid, rsp_tready, rsp_tdata[55:0] | accepted, latest_seq, ack_mask
//
// An item runs from one acceptance to the next as follows: the slot index is latched at
// acceptance, then the slot is read, the item is decided and written, the mask is walked
// over min(ACK_BITS, 32) slots, one slot a cycle through the single read port, the result
// is loaded and the next item is taken; no new item is accepted before the last one is
// through. WINDOW_SIZE is a power of two; the slot is the low bits of the number. After
// reset, a clearing pass invalidates every slot; no item is taken meanwhile. A stalled
// result waits in the output register while the next item is accepted; that item
// finishes only once the result has been taken.
module seq_receive_window_ack_bits
   import srw_pkg::*;
#(
   parameter int WINDOW_SIZE = 1024,
   parameter int ACK_BITS    = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SEQ_W-1:0]       req_tdata,  // [15:0] seq_number
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // [0] accepted, [16:1] latest_seq,
                                              // [48:17] ack_mask, [55:49] zero
);

   localparam int SLOT_W = $clog2(WINDOW_SIZE);
   localparam int ACK_N  = (ACK_BITS < MASK_W) ? ACK_BITS : MASK_W;
   localparam int CNT_W  = $clog2(ACK_N + 2);
   localparam int PAD_W  = RSP_TDATA_W - 1 - SEQ_W - MASK_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(65535 % WINDOW_SIZE);
   localparam logic [SLOT_W-1:0] TOP_SLOT  = SLOT_W'(WINDOW_SIZE - 1);
   localparam logic [SEQ_W-1:0]  WIN_SPAN  = SEQ_W'(WINDOW_SIZE);

   // Slot of the sequence number just below seq, given the slot of seq.
   function automatic logic [SLOT_W-1:0] slot_dec(input logic [SEQ_W-1:0] seq,
                                                   input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] res;
      if (seq == '0) begin
         res = LAST_SLOT;
      end else if (slot == '0) begin
         res = TOP_SLOT;
      end else begin
         res = slot - 1'b1;
      end
      return res;
   endfunction

   state_type              state_ff, state_in;
   ctrl_type               ctrl;
   logic [SLOT_W-1:0]      clr_ff;
   logic [SEQ_W-1:0]       seq_ff;
   logic [SLOT_W-1:0]      slot_ff;
   logic [SEQ_W-1:0]       newest_ff, newest_in;
   logic [SLOT_W-1:0]      newest_slot_ff, newest_slot_in;
   logic                   ok_ff;
   logic [MASK_W-1:0]      mask_ff;
   logic [SEQ_W-1:0]       mask_seq_ff;
   logic [SLOT_W-1:0]      mask_slot_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   chk_vld_ff;
   logic [SEQ_W-1:0]       chk_seq_ff;
   logic [MASK_IDX_W-1:0]  chk_idx_ff;
   logic                   rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;

   logic                   mod_done;
   logic [SLOT_W-1:0]      mod_rem;
   logic                   wr_en;
   logic [SLOT_W-1:0]      wr_addr;
   slot_type               wr_data;
   logic [SLOT_W-1:0]      rd_addr;
   slot_type               rd_data;
   logic                   item_held;
   logic                   item_ok;
   logic                   item_adv;
   logic                   issue;
   logic                   mask_hit;

   // Slot index of the incoming number.
   srw_mod_unit #(
      .WINDOW_SIZE(WINDOW_SIZE)
   ) u_mod (
      .clock(clock),
      .reset(reset),
      .start(ctrl.mod_start),
      .value(req_tdata),
      .done (mod_done),
      .rem  (mod_rem)
   );

   // Window store.
   srw_slot_ram #(
      .DEPTH(WINDOW_SIZE)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Item decision, valid in the check state once the slot has been read.
   always_comb begin
      item_held      = rd_data.valid && (rd_data.seq == seq_ff);
      item_ok        = seq_newer(seq_ff, newest_ff - WIN_SPAN) && !item_held;
      item_adv       = item_ok && seq_newer(seq_ff, newest_ff);
      newest_in      = item_adv ? seq_ff : newest_ff;
      newest_slot_in = item_adv ? slot_ff : newest_slot_ff;
   end

   // Mask walk: issue one read while slots remain, check the one read before.
   assign issue    = cnt_ff <= CNT_W'(ACK_N);
   assign mask_hit = chk_vld_ff && rd_data.valid && (rd_data.seq == chk_seq_ff);

   // Memory port selection.
   always_comb begin
      wr_en   = ctrl.wr_clear || ctrl.wr_item;
      wr_addr = ctrl.wr_clear ? clr_ff : slot_ff;
      wr_data = ctrl.wr_clear ? slot_type'('0) : slot_type'{valid: 1'b1, seq: seq_ff};
      rd_addr = ctrl.rd_item ? mod_rem : mask_slot_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == TOP_SLOT) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_MOD;
         end
         ST_MOD: begin
            if (mod_done) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = ST_MASK;
         end
         ST_MASK: begin
            if (!issue) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_CLEAR: ctrl.wr_clear = 1'b1;
         ST_IDLE: begin
            ctrl.ready     = 1'b1;
            ctrl.mod_start = req_tvalid;
         end
         ST_MOD:   ctrl.rd_item = 1'b1;
         ST_CHECK: ctrl.wr_item = item_ok;
         ST_MASK:  ctrl = '0;
         ST_DONE:  ctrl.load_rsp = !rsp_tvalid_ff || rsp_tready;
         default:  ctrl = '0;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         newest_ff      <= '0;
         newest_slot_ff <= '0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ctrl.wr_clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (state_ff == ST_CHECK) begin
            newest_ff      <= newest_in;
            newest_slot_ff <= newest_slot_in;
         end
         if (ctrl.load_rsp) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Item datapath and mask walk.
   always_ff @(posedge clock) begin
      if (ctrl.mod_start) begin
         seq_ff <= req_tdata;
      end
      if (ctrl.rd_item && mod_done) begin
         slot_ff <= mod_rem;
      end
      if (state_ff == ST_CHECK) begin
         ok_ff        <= item_ok;
         mask_ff      <= '0;
         mask_seq_ff  <= newest_in - 1'b1;
         mask_slot_ff <= slot_dec(newest_in, newest_slot_in);
         cnt_ff       <= CNT_W'(1);
         chk_vld_ff   <= 1'b0;
      end
      if (state_ff == ST_MASK) begin
         if (mask_hit) begin
            mask_ff[chk_idx_ff] <= 1'b1;
         end
         chk_vld_ff <= issue;
         if (issue) begin
            chk_seq_ff   <= mask_seq_ff;
            chk_idx_ff   <= MASK_IDX_W'(cnt_ff - 1'b1);
            mask_seq_ff  <= mask_seq_ff - 1'b1;
            mask_slot_ff <= slot_dec(mask_seq_ff, mask_slot_ff);
            cnt_ff       <= cnt_ff + 1'b1;
         end
      end
      if (ctrl.load_rsp) begin
         rsp_tdata_ff <= {{PAD_W{1'b0}}, mask_ff, newest_ff, ok_ff};
      end
   end

   assign req_tready = ctrl.ready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // The reduction unit finishes only while the sequencer waits for it.
   a_mod_done_in_mod: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == ST_MOD))
      else $error("slot reduction finished outside its state");

   // A slot index from the reduction always lies inside the window.
   a_mod_rem_range: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (int'(mod_rem) < WINDOW_SIZE))
      else $error("slot index beyond the window");

   // The mask walk never runs past the last acknowledged number.
   a_mask_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MASK) |-> (cnt_ff <= CNT_W'(ACK_N + 1)))
      else $error("mask walk overran");

   // A new result appears only after the walk has completed.
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result loaded before the mask was complete");

endmodule
